// ===== rtl/ogi_pkg.sv =====
// Shared types and constants for the occupancy grid inflation core.
// Used by the top level, front end, queue and back end; depends on nothing.
package ogi_pkg;

    localparam int VAL_BITS   = 8;
    localparam int WID_BITS   = 11;
    localparam int RAD_BITS   = 3;
    localparam int CELLS_BITS = 21;
    localparam int DIST_BITS  = 15;
    localparam int OFS_BITS   = 17;
    localparam int CNT_BITS   = 32;
    localparam int IDX_BITS   = 2;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_RADIUS = 4;
    localparam int DEF_MAX_CELLS  = 1048576;

    localparam logic [WID_BITS-1:0]   RST_WIDTH  = 11'd1024;
    localparam logic [RAD_BITS-1:0]   RST_RADIUS = 3'd0;
    localparam logic [CELLS_BITS-1:0] RST_CELLS  = 21'd1048576;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    typedef enum logic [IDX_BITS-1:0] {
        CFG_MAP_WIDTH    = 2'd0,
        CFG_RADIUS_CELLS = 2'd1,
        CFG_MAP_CELLS    = 2'd2
    } t_cfg_idx;

    // Clamped and derived configuration
    typedef struct packed {
        logic [WID_BITS-1:0]   width;
        logic [RAD_BITS-1:0]   radius;
        logic [CELLS_BITS-1:0] cells;
        logic [DIST_BITS-1:0]  lag;
        logic [DIST_BITS:0]    lag2;
        logic                  narrow;
    } t_cfg;

    // Per-item classification: offset window of eligible sources
    typedef struct packed {
        logic                has_result;
        logic                last;
        logic [OFS_BITS-1:0] o_min;
        logic [OFS_BITS-1:0] o_max;
    } t_meta;

    typedef struct packed {
        logic [VAL_BITS-1:0] value;
        t_meta               meta;
    } t_item;

endpackage

// ===== rtl/occupancy_grid_inflation_core.sv =====
// Top level of the occupancy grid inflation core: configuration registers,
// front end, queue and back end. Depends on ogi_pkg, ogi_front, ogi_fifo, ogi_back.
//
// Usage:
//   Slave stream carries one grid cell per transfer in raster order (tdata =
//   cell_value, tuser = pad). After the last cell send radius*width+radius pad
//   transfers to flush. Master stream returns one inflated cell per transfer
//   in raster order, tlast on the final grid cell; the first pad-delay inputs
//   give no result.
//   Throughput: one cell per cycle while no refill, full queue or stalled receiver
//   holds it, set by the window stage and one read per row buffer per cycle. Each
//   result passes the queue, the window stage and the output register in turn.
//   Configuration: write map_width (0), radius_cells (1), map_cells (2) only
//   while idle. Every write starts a refill of the window from the row
//   buffers, during which tready is low.
//   Reset clears counters, queue and valid flags; registers return to
//   width 1024, radius 0, 1048576 cells.
//   When the receiver stalls, the output register holds and the queue fills;
//   tready drops once the queue is full.
module occupancy_grid_inflation_core #(
    parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS,
    parameter int MAX_CELLS  = ogi_pkg::DEF_MAX_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [20:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] cell_value
    input  logic        i_s_tuser,   // [0] pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] inflated_value
    output logic        o_m_tlast    // last_cell
);

    logic [ogi_pkg::WID_BITS-1:0]   r_width;
    logic [ogi_pkg::RAD_BITS-1:0]   r_radius;
    logic [ogi_pkg::CELLS_BITS-1:0] r_cells;
    logic [ogi_pkg::WID_BITS-1:0]   w_c;
    logic [ogi_pkg::RAD_BITS-1:0]   r_c;
    ogi_pkg::t_cfg                  cfg;
    ogi_pkg::t_item                 f_item;
    ogi_pkg::t_item                 q_item;
    logic                           push;
    logic                           pop;
    logic                           q_valid;
    logic                           q_full;
    logic                           busy;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ogi_pkg::RST_WIDTH;
            r_radius <= ogi_pkg::RST_RADIUS;
            r_cells  <= ogi_pkg::RST_CELLS;
        end else if (i_cfg_we) begin
            case (ogi_pkg::t_cfg_idx'(i_cfg_idx))
                ogi_pkg::CFG_MAP_WIDTH:    r_width  <= i_cfg_wdata[10:0];
                ogi_pkg::CFG_RADIUS_CELLS: r_radius <= i_cfg_wdata[2:0];
                ogi_pkg::CFG_MAP_CELLS:    r_cells  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp and derive the pad delay
    always_comb begin
        w_c = (32'(r_width) > 32'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_width;
        r_c = (32'(r_radius) > 32'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : r_radius;
        cfg.width  = w_c;
        cfg.radius = r_c;
        cfg.cells  = (32'(r_cells) > 32'(MAX_CELLS)) ? 21'(MAX_CELLS) : r_cells;
        cfg.lag    = 15'({12'b0, r_c} * {4'b0, w_c}) + 15'(r_c);
        cfg.lag2   = {cfg.lag, 1'b0};
        cfg.narrow = (w_c <= {7'b0, r_c, 1'b0});
    end

    ogi_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg      (cfg),
        .i_busy     (busy),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_item     (f_item)
    );

    ogi_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (q_item)
    );

    ogi_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_start    (i_cfg_we),
        .o_busy     (busy),
        .i_q_valid  (q_valid),
        .i_item     (q_item),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/ogi_front.sv =====
// Front end: accepts raster cells, counts them and classifies each one.
// Depends on ogi_pkg; feeds ogi_fifo.
module ogi_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    input  logic [7:0]     i_s_tdata,   // [7:0] cell_value
    input  logic           i_s_tuser,   // [0] pad
    input  ogi_pkg::t_cfg  i_cfg,
    input  logic           i_busy,
    input  logic           i_q_full,
    output logic           o_push,
    output ogi_pkg::t_item o_item
);

    logic [ogi_pkg::CNT_BITS-1:0] r_items;
    logic                         accept;
    logic                         sat;
    logic signed [33:0]           p;
    logic signed [33:0]           lo;
    logic signed [33:0]           cells_s;
    logic signed [33:0]           dist2_s;

    assign o_s_tready = !i_q_full && !i_busy;
    assign accept     = i_s_tvalid && o_s_tready;
    assign sat        = &r_items;
    assign o_push     = accept && !sat;

    // Count transfers, saturating at the top value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items <= '0;
        end else if (accept && !sat) begin
            r_items <= r_items + 1'b1;
        end
    end

    // Classify: output position and window of eligible source offsets
    always_comb begin
        cells_s = $signed({13'b0, i_cfg.cells});
        dist2_s = $signed({18'b0, i_cfg.lag2});
        p       = $signed({2'b0, r_items}) - $signed({19'b0, i_cfg.lag});
        lo      = p + dist2_s - cells_s;
        o_item.value           = i_s_tuser ? 8'd0 : i_s_tdata;
        o_item.meta.has_result = !p[33] && (p < cells_s);
        o_item.meta.last       = (p == cells_s - 34'sd1);
        if (p >= dist2_s) begin
            o_item.meta.o_max = {1'b0, i_cfg.lag2};
        end else begin
            o_item.meta.o_max = p[16:0];
        end
        if (lo < 34'sd0) begin
            o_item.meta.o_min = '0;
        end else if (lo >= dist2_s) begin
            o_item.meta.o_min = {1'b0, i_cfg.lag2} + 17'd1;
        end else begin
            o_item.meta.o_min = lo[16:0] + 17'd1;
        end
    end

endmodule

// ===== rtl/ogi_fifo.sv =====
// Short queue of classified cells between front and back end.
// Depends on ogi_pkg.
module ogi_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ogi_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output ogi_pkg::t_item o_item
);

    ogi_pkg::t_item           r_mem [ogi_pkg::Q_DEPTH];
    logic [ogi_pkg::Q_AW-1:0] r_wr;
    logic [ogi_pkg::Q_AW-1:0] r_rd;
    logic [ogi_pkg::Q_AW:0]   r_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == (ogi_pkg::Q_AW+1)'(ogi_pkg::Q_DEPTH));
    assign o_item  = r_mem[r_rd];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ogi_back.sv =====
// Back end: row line buffers, square window, source selection, output register.
// Depends on ogi_pkg; takes items from ogi_fifo.
module ogi_back #(
    parameter int MAX_WIDTH  = ogi_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = ogi_pkg::DEF_MAX_RADIUS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ogi_pkg::t_cfg  i_cfg,
    input  logic           i_start,
    output logic           o_busy,
    input  logic           i_q_valid,
    input  ogi_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast
);

    localparam int NC    = 2 * MAX_RADIUS + 1;
    localparam int NAR   = (2 * MAX_RADIUS < MAX_WIDTH) ? 2 * MAX_RADIUS : MAX_WIDTH;
    localparam int LN    = 2 * MAX_RADIUS * NAR + NC;
    localparam int SPAN  = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
    localparam int AW    = (SPAN > 1) ? $clog2(SPAN) : 1;
    localparam int DEPTH = 2 ** AW;
    localparam int CW    = $clog2(NC + 1);

    logic [7:0]                  r_line [LN];
    logic [7:0]                  win [NC][NC];
    logic [ogi_pkg::OFS_BITS-1:0] aw_c [NC];
    logic [AW-1:0]               r_wp;
    logic [CW-1:0]               r_rf_cnt;
    logic [CW-1:0]               rf_b;
    logic                        en;
    logic                        r_m1_valid;
    ogi_pkg::t_meta              r_m1;
    logic                        r_out_valid;
    logic [7:0]                  r_out_val;
    logic                        r_out_last;
    logic [7:0]                  pick;

    assign o_busy     = (r_rf_cnt != '0);
    assign rf_b       = r_rf_cnt - 1'b1;
    assign en         = !r_out_valid || i_m_tready;
    assign o_pop      = en && i_q_valid && !o_busy;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_val;
    assign o_m_tlast  = r_out_last;

    // Refill pass after a configuration write, one column a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_cnt <= '0;
        end else if (i_start) begin
            r_rf_cnt <= CW'(NC);
        end else if (o_busy) begin
            r_rf_cnt <= r_rf_cnt - 1'b1;
        end
    end

    // Write pointer of the row buffers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
        end else if (o_pop) begin
            r_wp <= r_wp + 1'b1;
        end
    end

    // Shift the newest row, long enough for narrow maps
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_line[0] <= i_item.value;
            for (int n = 1; n < LN; n++) begin
                r_line[n] <= r_line[n-1];
            end
        end
    end

    // Older rows: one buffer each, read a whole row stride back
    for (genvar a = 0; a < NC; a++) begin : g_row
        if (a == 0) begin : g_head
            for (genvar b = 0; b < NC; b++) begin : g_col
                assign win[0][b] = r_line[b];
            end
        end else begin : g_buf
            logic [7:0]    mem [DEPTH];
            logic [7:0]    r_tap [NC];
            logic [AW-1:0] aw;
            logic [AW-1:0] rd_addr;
            logic          rd_en;

            assign aw      = AW'(a * int'(i_cfg.width));
            assign rd_en   = o_pop || o_busy;
            assign rd_addr = o_pop ? (r_wp - aw) : (r_wp - 1'b1 - aw - AW'(rf_b));

            always_ff @(posedge i_clk) begin
                if (o_pop) begin
                    mem[r_wp] <= i_item.value;
                end
            end

            always_ff @(posedge i_clk) begin
                if (rd_en) begin
                    r_tap[0] <= mem[rd_addr];
                    for (int k = 1; k < NC; k++) begin
                        r_tap[k] <= r_tap[k-1];
                    end
                end
            end

            for (genvar b = 0; b < NC; b++) begin : g_col
                assign win[a][b] = r_tap[b];
            end
        end
    end

    // Row offsets in cells
    always_comb begin
        for (int a = 0; a < NC; a++) begin
            aw_c[a] = ogi_pkg::OFS_BITS'(a * int'(i_cfg.width));
        end
    end

    // Pick the eligible nonzero source with the smallest offset, else keep the centre cell
    always_comb begin
        logic [ogi_pkg::OFS_BITS-1:0] o;
        logic                         found;
        logic [7:0]                   sel;
        logic [7:0]                   centre;
        found  = 1'b0;
        sel    = '0;
        centre = '0;
        o      = '0;
        if (i_cfg.narrow) begin
            for (int n = 0; n < LN; n++) begin
                if (ogi_pkg::OFS_BITS'(n) == ogi_pkg::OFS_BITS'(i_cfg.lag)) begin
                    centre = r_line[n];
                end
                if (!found && ogi_pkg::OFS_BITS'(n) >= r_m1.o_min &&
                    ogi_pkg::OFS_BITS'(n) <= r_m1.o_max && r_line[n] != 8'd0) begin
                    found = 1'b1;
                    sel   = r_line[n];
                end
            end
        end else begin
            for (int a = 0; a < NC; a++) begin
                for (int b = 0; b < NC; b++) begin
                    o = aw_c[a] + ogi_pkg::OFS_BITS'(b);
                    if (a == int'(i_cfg.radius) && b == int'(i_cfg.radius)) begin
                        centre = win[a][b];
                    end
                    if (!found && b <= 2 * int'(i_cfg.radius) && o >= r_m1.o_min &&
                        o <= r_m1.o_max && win[a][b] != 8'd0) begin
                        found = 1'b1;
                        sel   = win[a][b];
                    end
                end
            end
        end
        pick = found ? sel : centre;
    end

    // Window stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_valid <= 1'b0;
        end else if (en) begin
            r_m1_valid <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1 <= i_item.meta;
        end
    end

    // Output register: hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_m1_valid && r_m1.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_val  <= pick;
            r_out_last <= r_m1.last;
        end
    end

endmodule

// ===== rtl/ogi_checker.sv =====
// Port-level checks for the occupancy grid inflation core, bound to the top.
// Depends on occupancy_grid_inflation_core ports only.
module ogi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result changed");

    // A configuration write blocks input during the refill
    a_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_s_tready)
        else $error("input accepted during refill");

    // Reset leaves no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind occupancy_grid_inflation_core ogi_checker u_ogi_checker (.*);
